/* src/bfz_pkg.sv */
// ---------------------------------------------------------------------------
// bfz_pkg
// Types, constants and helpers shared by the bitmap allocator modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfz_pkg;

  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = 32;
  localparam int MAX_BITS   = 1024;
  localparam int CNT_W      = 11;
  localparam int BIT_W      = 10;
  localparam int WIDX_W     = 5;
  localparam int BPOS_W     = 5;
  localparam int NW_W       = 6;
  localparam int CMD_W      = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 3'd0,
    CMD_CLR    = 3'd1,
    CMD_TEST   = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_CLRALL = 3'd4,
    CMD_LOAD   = 3'd5
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [BIT_W-1:0]     bit_index;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_data;
  } item_t;

  typedef struct packed {
    logic             ok;
    logic [BIT_W-1:0] found_index;
  } result_t;

  typedef struct packed {
    logic [WIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 clr_all;
  } map_req_t;

  typedef struct packed {
    logic [WIDX_W-1:0] addr;
    logic [CNT_W-1:0]  count;
  } scan_req_t;

  typedef struct packed {
    logic             zero_found;
    logic             in_range;
    logic [BIT_W-1:0] index;
  } scan_res_t;

  function automatic logic [BPOS_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BPOS_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BPOS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* src/bfz_map.sv */
// ---------------------------------------------------------------------------
// bfz_map
// Bitmap word store: one write port, one registered read port, per-word
// valid bits so that reset and clear-all read back as zero words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfz_map
  import bfz_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  map_req_t             req_i,
  output logic [WORD_BITS-1:0] rd_word_o
);

  logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_q <= mem_q[req_i.rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[req_i.rd_addr];
      if (req_i.clr_all) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_word_o = rd_vld_q ? rd_data_q : '0;

endmodule

/* src/bfz_scan.sv */
// ---------------------------------------------------------------------------
// bfz_scan
// Word scan unit: locates the lowest zero bit of one word and checks the
// resulting bit index against the tracked bit count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfz_scan
  import bfz_pkg::*;
(
  input  logic [WORD_BITS-1:0] word_i,
  input  scan_req_t            req_i,
  output scan_res_t            res_o
);

  logic [BPOS_W-1:0] pos;
  logic [BIT_W-1:0]  idx;

  assign pos = first_zero(word_i);
  assign idx = {req_i.addr, pos};

  assign res_o.zero_found = ~&word_i;
  assign res_o.in_range   = {1'b0, idx} < req_i.count;
  assign res_o.index      = idx;

endmodule

/* src/bfz_ctrl.sv */
// ---------------------------------------------------------------------------
// bfz_ctrl
// Command sequencer: latches a command, drives the word store and the scan
// unit one word per cycle, keeps the search hint and the bit count register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfz_ctrl
  import bfz_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  item_t                item_i,
  output logic                 busy,
  input  logic                 cfg_valid_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  output logic                 cfg_ready_o,
  input  logic [WORD_BITS-1:0] rd_word_i,
  output map_req_t             map_req_o,
  output scan_req_t            scan_req_o,
  input  scan_res_t            scan_res_i,
  output logic                 res_strobe_o,
  output result_t              res_o
);

  state_e            state_q, state_d;
  item_t             item_q;
  logic [WIDX_W-1:0] addr_q, addr_d;
  logic [WIDX_W-1:0] hint_q, hint_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              strobe_q;
  result_t           res_q, res_d;
  logic              done;

  logic [CNT_W-1:0]  eff_cnt;
  logic [CNT_W:0]    cnt_rnd;
  logic [NW_W-1:0]   nw;
  logic [NW_W-1:0]   addr_inc;
  logic              idx_ok;
  logic [WORD_BITS-1:0] mask;
  logic              accept;

  assign accept   = start && (state_q == ST_IDLE);
  assign eff_cnt  = (cnt_q > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : cnt_q;
  assign cnt_rnd  = {1'b0, eff_cnt} + (CNT_W+1)'(WORD_BITS - 1);
  assign nw       = cnt_rnd[BPOS_W+NW_W-1:BPOS_W];
  assign addr_inc = {1'b0, addr_q} + NW_W'(1);
  assign idx_ok   = {1'b0, item_q.bit_index} < eff_cnt;
  assign mask     = WORD_BITS'(1) << item_q.bit_index[BPOS_W-1:0];

  assign scan_req_o.addr  = addr_q;
  assign scan_req_o.count = eff_cnt;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    done              = 1'b0;
    res_d             = '0;
    addr_d            = addr_q;
    hint_d            = hint_q;
    map_req_o         = '0;
    map_req_o.rd_addr = addr_q;
    case (state_q)
      ST_IDLE: begin
        if (item_i.command == CMD_FIND) begin
          addr_d = hint_q;
        end else begin
          addr_d = item_i.bit_index[BIT_W-1:BPOS_W];
        end
        map_req_o.rd_addr = addr_d;
      end
      ST_EXEC: begin
        done = 1'b1;
        case (item_q.command)
          CMD_SET: begin
            if (idx_ok) begin
              map_req_o.wr_en   = 1'b1;
              map_req_o.wr_addr = addr_q;
              map_req_o.wr_data = rd_word_i | mask;
              res_d.ok          = 1'b1;
            end
          end
          CMD_CLR: begin
            if (idx_ok) begin
              map_req_o.wr_en   = 1'b1;
              map_req_o.wr_addr = addr_q;
              map_req_o.wr_data = rd_word_i & ~mask;
              hint_d            = '0;
              res_d.ok          = 1'b1;
            end
          end
          CMD_TEST: begin
            res_d.ok = idx_ok && ((rd_word_i & mask) != '0);
          end
          CMD_FIND: begin
            if ({1'b0, addr_q} < nw) begin
              if (scan_res_i.zero_found) begin
                if (scan_res_i.in_range) begin
                  res_d.ok          = 1'b1;
                  res_d.found_index = scan_res_i.index;
                  hint_d            = addr_q;
                end
              end else if (addr_inc < nw) begin
                done              = 1'b0;
                addr_d            = addr_inc[WIDX_W-1:0];
                map_req_o.rd_addr = addr_d;
              end
            end
          end
          CMD_CLRALL: begin
            map_req_o.clr_all = 1'b1;
            res_d.ok          = 1'b1;
          end
          CMD_LOAD: begin
            if ({1'b0, item_q.word_index} < nw) begin
              map_req_o.wr_en   = 1'b1;
              map_req_o.wr_addr = item_q.word_index;
              map_req_o.wr_data = item_q.word_data;
              res_d.ok          = 1'b1;
            end
          end
          default: begin
            res_d = '0;
          end
        endcase
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      addr_q   <= '0;
      hint_q   <= '0;
      cnt_q    <= CNT_W'(MAX_BITS);
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      hint_q   <= hint_d;
      strobe_q <= (state_q == ST_EXEC) && done;
      if (cfg_valid_i && cfg_ready_o) begin
        cnt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    res_q <= res_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign cfg_ready_o  = (state_q == ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

/* src/bitmap_allocator_find_first_zero_top.sv */
// ---------------------------------------------------------------------------
// bitmap_allocator_find_first_zero_top
// Bitmap allocator over 32 words of 32 bits with set, clear, test,
// find-first-zero, clear-all and load-word commands.
//
//   channel   signals                         handshake
//   command   start, item_i                   beat when start & !busy
//   config    cfg_valid_i, cfg_data_i         beat when cfg_valid_i & cfg_ready_o
//   result    res_strobe_o, res_o             one-cycle strobe, no backpressure
//
// Find holds busy while it scans the bitmap words one at a time (1 to 32 words),
// limited by the single read port of the word store; every other command
// finishes on its first pass through ST_EXEC. The result strobe rises in the
// cycle that busy drops. A new command beat may land in the strobe cycle.
// Reset clears the per-word valid bits at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_allocator_find_first_zero_top
  import bfz_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  item_t            item_i,
  output logic             busy,
  input  logic             cfg_valid_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  output logic             cfg_ready_o,
  output logic             res_strobe_o,
  output result_t          res_o
);

  map_req_t             map_req;
  scan_req_t            scan_req;
  scan_res_t            scan_res;
  logic [WORD_BITS-1:0] rd_word;

  bfz_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .item_i       (item_i),
    .busy         (busy),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_ready_o  (cfg_ready_o),
    .rd_word_i    (rd_word),
    .map_req_o    (map_req),
    .scan_req_o   (scan_req),
    .scan_res_i   (scan_res),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  bfz_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .rd_word_o (rd_word)
  );

  bfz_scan u_scan (
    .word_i (rd_word),
    .req_i  (scan_req),
    .res_o  (scan_res)
  );

endmodule

/* src/bfz_chk.sv */
// ---------------------------------------------------------------------------
// bfz_chk
// Port-level checks for the bitmap allocator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfz_chk
  import bfz_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    cfg_ready_o,
  input logic    res_strobe_o,
  input result_t res_o
);

  a_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command beat did not raise busy");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_strobe_o)
    else $error("busy dropped without a result beat");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (!busy && cfg_ready_o))
    else $error("result beat while busy");

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o)
    else $error("back-to-back result beats");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.ok) |-> (res_o.found_index == '0))
    else $error("failed result carries a nonzero index");

endmodule

bind bitmap_allocator_find_first_zero_top bfz_chk u_bfz_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .cfg_ready_o  (cfg_ready_o),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);
